/* design/rss_pkg.sv */
// shared types, constants and helpers of the relay step sequencer
// no dependencies; compiled before every other file of the block
`default_nettype none

package rss_pkg;

  localparam int RELAYS  = 8;
  localparam int STEPS   = 8;
  localparam int LVL_W   = 8;
  localparam int RELAY_W = (RELAYS > 1) ? $clog2(RELAYS) : 1;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int SIU_W   = $clog2(STEPS + 1);
  localparam int CNT_W   = $clog2(RELAYS + 1);
  localparam int ADDR_W  = (RELAYS * STEPS > 1) ? $clog2(RELAYS * STEPS) : 1;

  typedef logic [RELAY_W-1:0] relay_idx_t;
  typedef logic [STEP_W-1:0]  step_idx_t;
  typedef logic [SIU_W-1:0]   siu_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_WRITE = 2'd1,
    FN_ARM   = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ARM   = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  relay_index;
    logic [2:0]  step_index;
    logic        step_level;
    logic [31:0] period_ticks;
    logic [31:0] delay_ticks;
    logic [31:0] cycles;
    logic [3:0]  step_count;
  } in_req_t;

  typedef struct packed {
    logic [LVL_W-1:0] relay_levels;
    logic [LVL_W-1:0] driven_mask;
  } out_req_t;

  // one slot of a step table
  typedef struct packed {
    logic        level;
    logic [31:0] period;
  } step_t;

  // live state of one relay
  typedef struct packed {
    siu_t        siu;
    logic [31:0] delay;
    logic [31:0] cycles;
    step_idx_t   cur_step;
    logic [31:0] period;
    logic        level;
  } relay_state_t;

  function automatic addr_t step_addr(relay_idx_t r, step_idx_t s);
    return ADDR_W'(r) * ADDR_W'(STEPS) + ADDR_W'(s);
  endfunction

  // low relays as seen on the result port
  function automatic logic [LVL_W-1:0] to_vis(logic [RELAYS-1:0] v);
    logic [LVL_W-1:0] o;
    o = '0;
    for (int i = 0; i < LVL_W && i < RELAYS; i++) begin
      o[i] = v[i];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* design/rss_in_if.sv */
// request channel into the relay step sequencer
// depends on rss_pkg for the payload type
`default_nettype none

interface rss_in_if;
  logic             valid;
  logic             ready;
  rss_pkg::in_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

`default_nettype wire

/* design/rss_out_if.sv */
// result channel out of the relay step sequencer
// depends on rss_pkg for the payload type
`default_nettype none

interface rss_out_if;
  logic              valid;
  logic              ready;
  rss_pkg::out_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

`default_nettype wire

/* design/rss_step_mem.sv */
// step table memory: one write port, one registered read port
// depends on rss_pkg for address and entry types
`default_nettype none

module rss_step_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  rss_pkg::addr_t  waddr_i,
  input  rss_pkg::step_t  wdata_i,
  input  rss_pkg::addr_t  raddr_i,
  output rss_pkg::step_t  rdata_o
);
  import rss_pkg::*;

  step_t mem [RELAYS*STEPS];
  step_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/rss_tick_alu.sv */
// per-relay tick update: one shared 32-bit decrementer and zero checks
// depends on rss_pkg for relay state and step entry types
`default_nettype none

module rss_tick_alu (
  input  rss_pkg::relay_state_t st_i,
  input  rss_pkg::step_t        step_i,
  input  logic                  next_ok_i,
  output rss_pkg::relay_state_t st_o,
  output logic                  drive_o,
  output logic                  level_o
);
  import rss_pkg::*;

  logic [31:0] dec_in;
  logic [31:0] dec_out;
  logic        delay_nz;
  logic        period_nz;

  assign delay_nz  = (st_i.delay != '0);
  assign period_nz = (st_i.period != '0);

  // delay, period and cycle count never count down on the same tick
  always_comb begin
    if (delay_nz) begin
      dec_in = st_i.delay;
    end else if (period_nz) begin
      dec_in = st_i.period;
    end else begin
      dec_in = st_i.cycles;
    end
  end

  assign dec_out = dec_in - 32'd1;
  assign level_o = st_i.level;

  always_comb begin
    st_o    = st_i;
    drive_o = 1'b0;
    if (st_i.cycles != '0) begin
      if (delay_nz) begin
        st_o.delay = dec_out;
      end else if (period_nz) begin
        st_o.period = dec_out;
      end else begin
        drive_o = 1'b1;
        if (next_ok_i) begin
          st_o.cur_step = st_i.cur_step + 1'b1;
          st_o.period   = step_i.period;
          st_o.level    = step_i.level;
        end else begin
          // wrap to the first step; an empty table leaves the step as is
          if (st_i.siu != '0) begin
            st_o.cur_step = '0;
            st_o.period   = step_i.period;
            st_o.level    = step_i.level;
          end
          if (st_i.cycles != '1) begin
            st_o.cycles = dec_out;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/relay_step_sequencer.sv */
// relay step sequencer top level: sequencer, relay state and result register
// depends on rss_pkg, rss_in_if, rss_out_if, rss_step_mem and rss_tick_alu
//
//   channel  dir  payload                                              handshake
//   in_i     in   func, relay_index, step_index, step_level,           valid/ready
//                 period_ticks, delay_ticks, cycles, step_count
//   out_o    out  relay_levels, driven_mask (one per tick request)     valid/ready
//
// a write request completes in idle; an arm request loads step 0 in the arm state
// a tick request is accepted in idle, then walks the relays one per cycle through
//   the shared tick unit with each table read issued in the cycle before, then the
//   drain state loads the result
// in_i.ready is high only while the sequencer is idle; a tick whose result meets a
//   full output register waits in the drain state until out_o takes the old one
// reset clears all relay state and output levels; the step tables are not cleared
`default_nettype none

module relay_step_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  rss_in_if.sink         in_i,
  rss_out_if.source      out_o
);
  import rss_pkg::*;

  // sequencer
  state_e            state_q, state_d;
  cnt_t              cnt_q, cnt_d;
  relay_idx_t        arm_rel_q, arm_rel_d;

  // relay state and levels
  relay_state_t      rs_q [RELAYS];
  relay_state_t      rs_d [RELAYS];
  logic [RELAYS-1:0] lvl_q, lvl_d;
  logic [RELAYS-1:0] driven_q, driven_d;

  // relay being processed, latched when its table read is issued
  relay_state_t      prc_st_q, prc_st_d;
  relay_idx_t        prc_rel_q, prc_rel_d;
  logic              next_ok_q, next_ok_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  out_lvl_q, out_lvl_d;
  logic [LVL_W-1:0]  out_drv_q, out_drv_d;

  // table memory
  logic              mem_we;
  addr_t             mem_waddr;
  step_t             mem_wdata;
  addr_t             mem_raddr;
  step_t             mem_rdata;

  // tick unit
  relay_state_t      alu_st;
  logic              alu_drive;
  logic              alu_level;

  // issue side
  relay_idx_t        iss_rel;
  relay_state_t      iss_st;
  siu_t              iss_nxt;
  logic              iss_ok;
  step_idx_t         iss_step;

  logic              in_take;
  logic              rel_ok;
  logic              step_ok;
  relay_idx_t        req_rel;
  siu_t              req_siu;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_take       = in_i.valid && in_i.ready;
  assign rel_ok        = (int'(in_i.req.relay_index) < RELAYS);
  assign step_ok       = (int'(in_i.req.step_index) < STEPS);
  assign req_rel       = RELAY_W'(in_i.req.relay_index);
  assign req_siu       = (int'(in_i.req.step_count) > STEPS) ? SIU_W'(STEPS)
                                                            : SIU_W'(in_i.req.step_count);

  assign out_o.valid            = out_valid_q;
  assign out_o.req.relay_levels = out_lvl_q;
  assign out_o.req.driven_mask  = out_drv_q;

  // next step of the relay whose table read goes out this cycle
  assign iss_rel  = (int'(cnt_q) < RELAYS) ? RELAY_W'(cnt_q) : '0;
  assign iss_st   = rs_q[iss_rel];
  assign iss_nxt  = SIU_W'(iss_st.cur_step) + 1'b1;
  assign iss_ok   = (iss_nxt < iss_st.siu);
  assign iss_step = iss_ok ? STEP_W'(iss_nxt) : '0;

  // table writes come straight from the request
  assign mem_we          = in_take && (in_i.req.func == FN_WRITE) && rel_ok && step_ok;
  assign mem_waddr       = step_addr(req_rel, STEP_W'(in_i.req.step_index));
  assign mem_wdata.level = in_i.req.step_level;
  assign mem_wdata.period = in_i.req.period_ticks;

  // arm reads step 0 of its relay, a tick walks the relays
  assign mem_raddr = (state_q == ST_IDLE) ? step_addr(req_rel, '0)
                                          : step_addr(iss_rel, iss_step);

  rss_step_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rss_tick_alu u_alu (
    .st_i      (prc_st_q),
    .step_i    (mem_rdata),
    .next_ok_i (next_ok_q),
    .st_o      (alu_st),
    .drive_o   (alu_drive),
    .level_o   (alu_level)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    arm_rel_d   = arm_rel_q;
    rs_d        = rs_q;
    lvl_d       = lvl_q;
    driven_d    = driven_q;
    prc_st_d    = prc_st_q;
    prc_rel_d   = prc_rel_q;
    next_ok_d   = next_ok_q;
    out_valid_d = out_valid_q;
    out_lvl_d   = out_lvl_q;
    out_drv_d   = out_drv_q;

    // the waiting result leaves when taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          case (in_i.req.func)
            FN_TICK: begin
              cnt_d    = '0;
              driven_d = '0;
              state_d  = ST_TICK;
            end
            FN_ARM: begin
              if (rel_ok) begin
                rs_d[req_rel].siu      = req_siu;
                rs_d[req_rel].delay    = in_i.req.delay_ticks;
                rs_d[req_rel].cycles   = in_i.req.cycles;
                rs_d[req_rel].cur_step = '0;
                arm_rel_d              = req_rel;
                state_d                = ST_ARM;
              end
            end
            default: begin
              // writes go to the table directly, unknown codes are dropped
            end
          endcase
        end
      end
      ST_ARM: begin
        // step 0 is active only if the relay uses any steps
        if (rs_q[arm_rel_q].siu != '0) begin
          rs_d[arm_rel_q].period = mem_rdata.period;
          rs_d[arm_rel_q].level  = mem_rdata.level;
        end else begin
          rs_d[arm_rel_q].period = '0;
          rs_d[arm_rel_q].level  = 1'b0;
        end
        state_d = ST_IDLE;
      end
      ST_TICK: begin
        // update the relay whose table read went out last cycle
        if (cnt_q != '0) begin
          rs_d[prc_rel_q] = alu_st;
          if (alu_drive) begin
            lvl_d[prc_rel_q]    = alu_level;
            driven_d[prc_rel_q] = 1'b1;
          end
        end
        prc_st_d  = iss_st;
        prc_rel_d = iss_rel;
        next_ok_d = iss_ok;
        if (cnt_q == CNT_W'(RELAYS)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_lvl_d   = to_vis(lvl_q);
          out_drv_d   = to_vis(driven_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lvl_q       <= '0;
      driven_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RELAYS; i++) begin
        rs_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      driven_q    <= driven_d;
      out_valid_q <= out_valid_d;
      rs_q        <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arm_rel_q <= arm_rel_d;
    prc_st_q  <= prc_st_d;
    prc_rel_q <= prc_rel_d;
    next_ok_q <= next_ok_d;
    out_lvl_q <= out_lvl_d;
    out_drv_q <= out_drv_d;
  end

`ifndef SYNTHESIS
  // loading step 0 after an arm returns to idle in the next cycle
  a_arm_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ARM |=> state_q == ST_IDLE)
    else $error("arm load did not return to idle");

  // the relay walk counter never runs past RELAYS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK |-> int'(cnt_q) <= RELAYS)
    else $error("tick counter out of range");

  // a new result only appears at the end of a tick
  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DRAIN))
    else $error("result raised outside drain");

  // no request is taken while a tick is in flight
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK || state_q == ST_DRAIN) |-> !in_take)
    else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/relay_step_sequencer_checker.sv */
// request monitor, level predictor and result comparison for the relay step
// sequencer; depends on rss_pkg, rss_in_if and rss_out_if
`timescale 1ns / 100ps

module relay_step_sequencer_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rss_in_if    cmd_i,
  rss_out_if   res_i,
  output int   err_count_o,
  output int   open_ticks_o
);
  import rss_pkg::*;

  logic              slot_level  [RELAYS][STEPS];
  logic [31:0]       slot_period [RELAYS][STEPS];
  siu_t              steps_used  [RELAYS];
  logic [31:0]       delay_cnt   [RELAYS];
  logic [31:0]       cycles_cnt  [RELAYS];
  step_idx_t         step_ptr    [RELAYS];
  logic [31:0]       period_cnt  [RELAYS];
  logic              next_level  [RELAYS];
  logic [RELAYS-1:0] shown_levels;
  out_req_t          expected_levels [$];
  int                mismatches;

  // make step s of relay r active, refused past the steps in use
  function automatic bit load_slot(int r, int s);
    if (s >= int'(steps_used[r]) || s >= STEPS) return 1'b0;
    step_ptr[r]   = step_idx_t'(s);
    period_cnt[r] = slot_period[r][s];
    next_level[r] = slot_level[r][s];
    return 1'b1;
  endfunction

  function automatic out_req_t advance_relays();
    logic [RELAYS-1:0] driven;
    out_req_t          res;
    driven = '0;
    for (int r = 0; r < RELAYS; r++) begin
      if (cycles_cnt[r] == 0) continue;
      if (delay_cnt[r] != 0) begin
        delay_cnt[r] = delay_cnt[r] - 1;
        continue;
      end
      if (period_cnt[r] != 0) begin
        period_cnt[r] = period_cnt[r] - 1;
        continue;
      end
      shown_levels[r] = next_level[r];
      driven[r]       = 1'b1;
      if (!load_slot(r, int'(step_ptr[r]) + 1)) begin
        void'(load_slot(r, 0));
        if (cycles_cnt[r] != '1) cycles_cnt[r] = cycles_cnt[r] - 1;
      end
    end
    res.relay_levels = LVL_W'(shown_levels);
    res.driven_mask  = LVL_W'(driven);
    return res;
  endfunction

  function automatic void take_request(in_req_t q);
    int   r;
    int   s;
    siu_t n;
    r = int'(q.relay_index);
    s = int'(q.step_index);
    case (q.func)
      FN_TICK: begin
        expected_levels.push_back(advance_relays());
      end
      FN_WRITE: begin
        if (r < RELAYS && s < STEPS) begin
          slot_level[r][s]  = q.step_level;
          slot_period[r][s] = q.period_ticks;
        end
      end
      FN_ARM: begin
        if (r < RELAYS) begin
          n = (q.step_count > STEPS) ? siu_t'(STEPS) : siu_t'(q.step_count);
          steps_used[r] = n;
          delay_cnt[r]  = q.delay_ticks;
          cycles_cnt[r] = q.cycles;
          step_ptr[r]   = '0;
          if (!load_slot(r, 0)) begin
            period_cnt[r] = '0;
            next_level[r] = 1'b0;
          end
        end
      end
      default: ;  // unused function code is dropped
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_req_t want;
    if (!rst_ni) begin
      // tables keep their contents through reset
      for (int r = 0; r < RELAYS; r++) begin
        steps_used[r] = '0;
        delay_cnt[r]  = '0;
        cycles_cnt[r] = '0;
        step_ptr[r]   = '0;
        period_cnt[r] = '0;
        next_level[r] = 1'b0;
      end
      shown_levels = '0;
      expected_levels.delete();
      mismatches = 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) take_request(cmd_i.req);
      if (res_i.valid && res_i.ready) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected result: relay_levels %h, driven_mask %h",
                 res_i.req.relay_levels, res_i.req.driven_mask);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          if (res_i.req.relay_levels !== want.relay_levels) begin
            $error("relay_levels: expected %h, got %h",
                   want.relay_levels, res_i.req.relay_levels);
            mismatches++;
          end
          if (res_i.req.driven_mask !== want.driven_mask) begin
            $error("driven_mask: expected %h, got %h",
                   want.driven_mask, res_i.req.driven_mask);
            mismatches++;
          end
        end
      end
    end
    err_count_o  <= mismatches;
    open_ticks_o <= expected_levels.size();
  end

endmodule

/* tb/sv/relay_step_sequencer_test.sv */
// testbench top of the relay step sequencer: clock, reset, request and result
// traffic, watchdog and verdict; depends on rss_pkg, rss_in_if, rss_out_if,
// relay_step_sequencer and relay_step_sequencer_checker
`timescale 1ns / 100ps

module relay_step_sequencer_test;
  import rss_pkg::*;

  // function code the block has no use for
  localparam logic [1:0] FN_BAD = 2'd3;
  // requests that do something, directed and random part together
  localparam int RAND_REQS = 550;
  // longest legal silence is a sender gap, a whole tick and a receiver stall;
  // the tail wait adds to it
  localparam int QUIET_LIMIT = 500;
  // a tick walks every relay and then loads its result register
  localparam int TAIL_CYCLES = RELAYS + 6;

  logic             clk_i;
  logic             rst_ni;
  int               err_count;
  int               open_ticks;
  int               quiet_cycles = 0;
  int               useful_reqs = 0;
  int               calm_cmd = 0;
  int               calm_res = 0;
  // table slots written so far; an arm never reaches past them
  logic [STEPS-1:0] written [RELAYS];

  rss_in_if  cmd_if ();
  rss_out_if res_if ();

  relay_step_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  relay_step_sequencer_checker level_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .err_count_o  (err_count),
    .open_ticks_o (open_ticks)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // wait before the next request or result: mostly a random gap, with runs of
  // back-to-back traffic now and then
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 9);
  endfunction

  // a request of the given function with every other field random
  function automatic in_req_t scrambled_req(logic [1:0] fn);
    in_req_t q;
    q.func         = fn;
    q.relay_index  = 3'($urandom);
    q.step_index   = 3'($urandom);
    q.step_level   = 1'($urandom);
    q.period_ticks = $urandom();
    q.delay_ticks  = $urandom();
    q.cycles       = $urandom();
    q.step_count   = 4'($urandom);
    return q;
  endfunction

  // periods and delays: short mostly, so relays actually step within the run
  function automatic logic [31:0] short_count();
    case ($urandom_range(0, 24))
      0:       return $urandom();
      1:       return '1;
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  // pass counts: a few passes mostly, also stopped, forever and random
  function automatic logic [31:0] rand_cycles();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return 32'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_req(input in_req_t q);
    int gap;
    gap = draw_gap(calm_cmd);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.req   <= q;
    // ready is sampled as it stood just before the edge
    do @(posedge clk_i); while (!cmd_if.ready);
    if (q.func != FN_BAD) useful_reqs++;
  endtask

  task automatic write_slot(input int r, input int s, input logic lvl,
                            input logic [31:0] per);
    in_req_t q;
    q              = scrambled_req(FN_WRITE);
    q.relay_index  = relay_idx_t'(r);
    q.step_index   = step_idx_t'(s);
    q.step_level   = lvl;
    q.period_ticks = per;
    written[r][s]  = 1'b1;
    send_req(q);
  endtask

  task automatic arm_relay(input int r, input logic [31:0] dly,
                           input logic [31:0] reps, input logic [3:0] cnt);
    in_req_t q;
    q             = scrambled_req(FN_ARM);
    q.relay_index = relay_idx_t'(r);
    q.delay_ticks = dly;
    q.cycles      = reps;
    q.step_count  = cnt;
    send_req(q);
  endtask

  // result side: before every result, ready drops for a random stall that may be zero
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap(calm_res);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // watchdog: too long without any request or result taken ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("relay_step_sequencer_test: done, errors");
      $finish;
    end
  end

  initial begin
    int         pick;
    int         r;
    int         n;
    logic [3:0] cnt;
    rst_ni = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.req   <= '0;
    foreach (written[i]) written[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // nothing armed yet: all levels low, nothing driven
    send_req(scrambled_req(FN_TICK));
    // unused function code must leave no trace
    send_req(scrambled_req(FN_BAD));
    // relay 0: three steps after one tick of start delay, two passes
    write_slot(0, 0, 1'b1, 32'd0);
    write_slot(0, 1, 1'b0, 32'd1);
    write_slot(0, 2, 1'b1, 32'd2);
    arm_relay(0, 32'd1, 32'd2, 4'd3);
    // relay 1 with no steps, three passes: drives level 0 on each tick, each tick a whole pass
    arm_relay(1, 32'd0, 32'd3, 4'd0);
    // relay 2 armed with zero passes stays stopped
    arm_relay(2, 32'd0, 32'd0, 4'd0);
    // relay 7: longest possible period, runs forever
    write_slot(7, 0, 1'b1, '1);
    arm_relay(7, 32'd0, '1, 4'd1);
    // relay 6: longest delay, forever, no steps
    arm_relay(6, '1, '1, 4'd0);
    // relay 3: full table, step count above the table size saturates
    for (int s = 0; s < STEPS; s++) write_slot(3, s, 1'(s), 32'(s % 2));
    arm_relay(3, 32'd0, 32'd1, 4'd15);
    repeat (5) send_req(scrambled_req(FN_TICK));

    // ---- random part ----
    // mostly ticks and well-formed programs (fill steps, then arm),
    // plus stray writes, arms over old tables and unused codes
    while (useful_reqs < RAND_REQS) begin
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, RELAYS - 1);
      if (pick < 50) begin
        repeat ($urandom_range(1, 8)) send_req(scrambled_req(FN_TICK));
      end else if (pick < 72) begin
        n = $urandom_range(0, STEPS);
        for (int s = 0; s < n; s++) write_slot(r, s, 1'($urandom), short_count());
        cnt = 4'(n);
        if (n == STEPS && $urandom_range(0, 2) == 0) cnt = 4'($urandom_range(STEPS, 15));
        arm_relay(r, short_count(), rand_cycles(), cnt);
      end else if (pick < 84) begin
        write_slot(r, $urandom_range(0, STEPS - 1), 1'($urandom), short_count());
      end else if (pick < 93) begin
        // step count limited to the written head of the table
        n = 0;
        while (n < STEPS && written[r][n]) n++;
        if (n == STEPS && $urandom_range(0, 2) == 0) begin
          cnt = 4'($urandom_range(STEPS, 15));
        end else begin
          cnt = 4'($urandom_range(0, n));
        end
        arm_relay(r, short_count(), rand_cycles(), cnt);
      end else begin
        send_req(scrambled_req(FN_BAD));
      end
    end

    // ---- wind down ----
    cmd_if.valid <= 1'b0;
    // one edge so the last accepted tick shows up in the open count
    @(posedge clk_i);
    while (open_ticks != 0) @(posedge clk_i);
    // catch any stray result the block still puts out
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("relay_step_sequencer_test: done, clean");
    end else begin
      $display("relay_step_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule
